// ===== sv/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Types and constants shared by the bloom filter membership block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  // operation codes of an input transaction, also used as command kinds
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FILTER_BYTES = 2'd0;
  localparam logic [1:0] REG_HASH_COUNT   = 2'd1;
  localparam logic [1:0] REG_TWEAK        = 2'd2;

  // element length field, wide enough for the largest supported buffer
  localparam int unsigned LEN_W = 11;

  localparam logic [31:0] SEED_STEP  = 32'hfba4c795;
  localparam logic [5:0]  HASH_LIMIT = 6'd50;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic [14:0] filter_index;
  } bfm_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] element_count;
    logic        item_too_long;
  } bfm_out_t;

  typedef struct packed {
    logic [15:0] filter_bytes;
    logic [5:0]  hash_count;
    logic [31:0] tweak;
  } bfm_cfg_t;

  // work handed from the front part to the back part
  typedef struct packed {
    logic [1:0]       kind;
    logic             too_long;
    logic [LEN_W-1:0] len;
    logic [14:0]      addr;
    logic [7:0]       data;
  } bfm_cmd_t;

  // back part status seen by the front part
  typedef struct packed {
    logic clearing;
    logic release_buf;
  } bfm_bstat_t;

endpackage

`default_nettype wire

// ===== sv/bfm_queue.sv =====
// ----------------------------------------------------------------------------
// bfm_queue
// Two-entry queue of commands between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_queue #(
  parameter type T = logic
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  T     push_data_i,
  output logic full_o,
  output logic pop_valid_o,
  input  wire  pop_i,
  output T     pop_data_o
);

  T           mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;

  assign full_o      = cnt_q == 2'd2;
  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && pop_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop_i && pop_valid_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= ~wp_q;
      if (pop_i && pop_valid_o) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ===== sv/bfm_front.sv =====
// ----------------------------------------------------------------------------
// bfm_front
// Accepts input transactions, buffers element bytes and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_front import bfm_pkg::*; #(
  parameter int unsigned MAX_ITEM_BYTES = 64
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  bfm_in_t                               in_data_i,
  input  bfm_bstat_t                            bstat_i,
  input  wire                                   q_full_i,
  output logic                                  q_push_o,
  output bfm_cmd_t                              q_cmd_o,
  input  wire  [$clog2(MAX_ITEM_BYTES)-1:0]     buf_raddr_i,
  output logic [7:0]                            buf_rdata_o
);

  localparam int unsigned AW = $clog2(MAX_ITEM_BYTES);
  localparam int unsigned LW = $clog2(MAX_ITEM_BYTES + 1);

  logic [7:0]    buf_mem [MAX_ITEM_BYTES];
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic          busy_q, busy_d;
  logic          accept, is_elem, room, buf_we;

  assign in_ready_o = !q_full_i && !busy_q && !bstat_i.clearing;
  assign accept     = in_valid_i && in_ready_o;
  assign is_elem    = in_data_i.operation == OP_INSERT || in_data_i.operation == OP_QUERY;
  assign room       = len_q < LW'(MAX_ITEM_BYTES);
  assign buf_we     = accept && is_elem && in_data_i.byte_valid && room;
  assign q_push_o   = accept && (!is_elem || in_data_i.last);

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    busy_d = busy_q;
    if (bstat_i.release_buf) busy_d = 1'b0;
    if (accept && is_elem) begin
      if (in_data_i.byte_valid) begin
        if (room) len_d = len_q + 1'b1;
        else      ovf_d = 1'b1;
      end
      if (in_data_i.last) begin
        len_d  = '0;
        ovf_d  = 1'b0;
        busy_d = 1'b1;
      end
    end
  end

  always_comb begin
    q_cmd_o.kind     = in_data_i.operation;
    q_cmd_o.too_long = ovf_q || (in_data_i.byte_valid && !room);
    q_cmd_o.len      = LEN_W'(len_q + LW'(in_data_i.byte_valid && room));
    q_cmd_o.addr     = in_data_i.filter_index;
    q_cmd_o.data     = in_data_i.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[len_q[AW-1:0]] <= in_data_i.data_byte;
    buf_rdata_o <= buf_mem[buf_raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/bfm_back.sv =====
// ----------------------------------------------------------------------------
// bfm_back
// Runs commands: hashes elements, updates or tests the filter memory.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_back import bfm_pkg::*; #(
  parameter int unsigned FILTER_MAX_BYTES = 32768,
  parameter int unsigned MAX_ITEM_BYTES   = 64
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  bfm_cfg_t                              cfg_i,
  input  wire                                   q_valid_i,
  output logic                                  q_pop_o,
  input  bfm_cmd_t                              q_cmd_i,
  output bfm_bstat_t                            bstat_o,
  output logic [$clog2(MAX_ITEM_BYTES)-1:0]     buf_raddr_o,
  input  wire  [7:0]                            buf_rdata_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output bfm_out_t                              out_data_o
);

  localparam int unsigned AW   = $clog2(MAX_ITEM_BYTES);
  localparam int unsigned LW   = $clog2(MAX_ITEM_BYTES + 1);
  localparam int unsigned FA_W = (FILTER_MAX_BYTES > 1) ? $clog2(FILTER_MAX_BYTES) : 1;
  localparam int unsigned FB_W = $clog2(FILTER_MAX_BYTES + 1);
  localparam int unsigned NB_W = FB_W + 3;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FET  = 4'd2;
  localparam logic [3:0] S_GET  = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_F1   = 4'd7;
  localparam logic [3:0] S_F2   = 4'd8;
  localparam logic [3:0] S_F3   = 4'd9;
  localparam logic [3:0] S_MOD  = 4'd10;
  localparam logic [3:0] S_MRD  = 4'd11;
  localparam logic [3:0] S_MUPD = 4'd12;
  localparam logic [3:0] S_RES  = 4'd13;

  logic [3:0]      st_q, st_d;
  logic [FA_W-1:0] clr_q, clr_d;
  logic [31:0]     h_q, h_d, k_q, k_d, seed_q, seed_d, cnt_q, cnt_d;
  logic [LW-1:0]   pos_q, pos_d, len_q, len_d;
  logic [5:0]      fn_q, fn_d;
  logic [4:0]      step_q, step_d;
  logic [NB_W-1:0] rem_q, rem_d;
  logic            all_q, all_d, ins_q, ins_d, tl_q, tl_d;
  logic            ov_q, ov_d;
  bfm_out_t        od_q, od_d;

  logic [7:0]      filt_mem [FILTER_MAX_BYTES];
  logic [7:0]      mem_rd_q;
  logic            mem_we;
  logic [FA_W-1:0] mem_addr;
  logic [7:0]      mem_wd;

  logic [31:0]     nbytes_w, x1, x2;
  logic [NB_W-1:0] nbits;
  logic [NB_W:0]   trial;
  logic [5:0]      nfuncs;
  logic [7:0]      bit_mask;
  logic            out_free;

  // filter length and hash count clamped into their working ranges
  always_comb begin
    nbytes_w = 32'(cfg_i.filter_bytes);
    if (nbytes_w == 32'd0) nbytes_w = 32'd1;
    else if (nbytes_w > 32'(FILTER_MAX_BYTES)) nbytes_w = 32'(FILTER_MAX_BYTES);
    nbits  = {nbytes_w[FB_W-1:0], 3'b000};
    nfuncs = (cfg_i.hash_count > HASH_LIMIT) ? HASH_LIMIT : cfg_i.hash_count;
  end

  assign out_free    = !ov_q || out_ready_i;
  assign buf_raddr_o = pos_q[AW-1:0];
  assign bit_mask    = 8'd1 << rem_q[2:0];
  assign trial       = {rem_q, h_q[31]};
  assign x1          = h_q ^ 32'(len_q);
  assign x2          = h_q ^ (h_q >> 13);

  always_comb begin
    st_d     = st_q;
    clr_d    = clr_q;
    h_d      = h_q;
    k_d      = k_q;
    seed_d   = seed_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    len_d    = len_q;
    fn_d     = fn_q;
    step_d   = step_q;
    rem_d    = rem_q;
    all_d    = all_q;
    ins_d    = ins_q;
    tl_d     = tl_q;
    ov_d     = ov_q && !out_ready_i;
    od_d     = od_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    mem_addr = rem_q[FA_W+2:3];
    mem_wd   = mem_rd_q | bit_mask;
    bstat_o.clearing    = st_q == S_CLR;
    bstat_o.release_buf = 1'b0;

    unique case (st_q)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        mem_wd   = 8'd0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == FA_W'(FILTER_MAX_BYTES - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        mem_addr = FA_W'(q_cmd_i.addr);
        mem_wd   = q_cmd_i.data;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.kind)
            OP_CLEAR: begin
              clr_d = '0;
              st_d  = S_CLR;
            end
            OP_LOAD: begin
              mem_we = 32'(q_cmd_i.addr) < 32'(FILTER_MAX_BYTES);
            end
            default: begin
              ins_d  = q_cmd_i.kind == OP_INSERT;
              tl_d   = q_cmd_i.too_long;
              len_d  = q_cmd_i.len[LW-1:0];
              fn_d   = 6'd0;
              all_d  = 1'b1;
              seed_d = cfg_i.tweak;
              h_d    = cfg_i.tweak;
              k_d    = 32'd0;
              pos_d  = '0;
              if (q_cmd_i.too_long || nfuncs == 6'd0) st_d = S_RES;
              else if (q_cmd_i.len == '0) st_d = S_F1;
              else st_d = S_FET;
            end
          endcase
        end
      end
      S_FET: st_d = S_GET;
      S_GET: begin
        k_d   = k_q | (32'(buf_rdata_i) << {pos_q[1:0], 3'b000});
        pos_d = pos_q + 1'b1;
        if (pos_q[1:0] == 2'd3 || LW'(pos_q + 1'b1) == len_q) st_d = S_M1;
        else st_d = S_FET;
      end
      S_M1: begin
        k_d  = k_q * MM_C1;
        st_d = S_M2;
      end
      S_M2: begin
        k_d  = {k_q[16:0], k_q[31:17]} * MM_C2;
        st_d = S_M3;
      end
      S_M3: begin
        h_d = h_q ^ k_q;
        // a full four-byte block also gets the rotate and multiply-add
        if (pos_q[1:0] == 2'd0) h_d = {h_d[18:0], h_d[31:19]} * 32'd5 + MM_N;
        k_d  = 32'd0;
        st_d = (pos_q == len_q) ? S_F1 : S_FET;
      end
      S_F1: begin
        h_d  = (x1 ^ (x1 >> 16)) * MM_F1;
        st_d = S_F2;
      end
      S_F2: begin
        h_d  = x2 * MM_F2;
        st_d = S_F3;
      end
      S_F3: begin
        h_d    = h_q ^ (h_q >> 16);
        rem_d  = '0;
        step_d = 5'd0;
        st_d   = S_MOD;
      end
      S_MOD: begin
        // restoring remainder, one dividend bit a cycle
        if (trial >= {1'b0, nbits}) rem_d = NB_W'(trial - {1'b0, nbits});
        else rem_d = trial[NB_W-1:0];
        h_d    = {h_q[30:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) st_d = S_MRD;
      end
      S_MRD: st_d = S_MUPD;
      S_MUPD: begin
        if (ins_q) mem_we = 1'b1;
        else if ((mem_rd_q & bit_mask) == 8'd0) all_d = 1'b0;
        fn_d   = fn_q + 6'd1;
        seed_d = seed_q + SEED_STEP;
        h_d    = seed_q + SEED_STEP;
        k_d    = 32'd0;
        pos_d  = '0;
        if (fn_q + 6'd1 == nfuncs) st_d = S_RES;
        else if (len_q == '0) st_d = S_F1;
        else st_d = S_FET;
      end
      S_RES: begin
        if (out_free) begin
          if (ins_q && !tl_q && len_q != '0 && cnt_q != 32'hffffffff) cnt_d = cnt_q + 32'd1;
          od_d.found         = !ins_q && !tl_q && all_q && len_q != '0;
          od_d.element_count = (ins_q && !tl_q && len_q != '0 && cnt_q != 32'hffffffff)
                               ? cnt_q + 32'd1 : cnt_q;
          od_d.item_too_long = tl_q;
          ov_d               = 1'b1;
          bstat_o.release_buf = 1'b1;
          st_d               = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      clr_q <= '0;
      cnt_q <= 32'd0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    k_q    <= k_d;
    seed_q <= seed_d;
    pos_q  <= pos_d;
    len_q  <= len_d;
    fn_q   <= fn_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    all_q  <= all_d;
    ins_q  <= ins_d;
    tl_q   <= tl_d;
    od_q   <= od_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) filt_mem[mem_addr] <= mem_wd;
    mem_rd_q <= filt_mem[mem_addr];
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

`default_nettype wire

// ===== sv/bloom_filter_membership.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_membership
// Bloom filter with MurmurHash3 x86_32 hashing over byte-stream elements.
// ----------------------------------------------------------------------------
// Element bytes are taken one per cycle, while in_ready_o is high, into a local
// buffer. On the last byte of an insert or query the back end hashes the
// element once per hash function: per function it fetches and gets each byte,
// mixes each four-byte block or tail, finalises, reduces the hash bit-serially
// modulo the filter size, and then reads and updates the filter memory; a
// further state takes the command from the queue and another registers the result.
// This per-function hash loop is what bounds the rate. A new element is
// accepted only after the previous result has been produced. After reset, and
// after each clear command, the filter memory is swept to zero at one byte per
// cycle while no input transaction is accepted; configuration writes are always
// taken.
`default_nettype none

module bloom_filter_membership import bfm_pkg::*; #(
  parameter int unsigned FILTER_MAX_BYTES = 32768,
  parameter int unsigned MAX_ITEM_BYTES   = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  bfm_in_t     in_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output bfm_out_t    out_data_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ITEM_BYTES);

  bfm_cfg_t   cfg_q;
  bfm_bstat_t bstat;
  bfm_cmd_t   push_cmd, pop_cmd;
  logic       q_full, q_push, q_valid, q_pop;
  logic [AW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_bytes <= 16'd1;
      cfg_q.hash_count   <= 6'd0;
      cfg_q.tweak        <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_BYTES: cfg_q.filter_bytes <= cfg_data_i[15:0];
        REG_HASH_COUNT:   cfg_q.hash_count   <= cfg_data_i[5:0];
        REG_TWEAK:        cfg_q.tweak        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bfm_front #(
    .MAX_ITEM_BYTES(MAX_ITEM_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .bstat_i     (bstat),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd),
    .buf_raddr_i (buf_raddr),
    .buf_rdata_o (buf_rdata)
  );

  bfm_queue #(
    .T(bfm_cmd_t)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_cmd)
  );

  bfm_back #(
    .FILTER_MAX_BYTES(FILTER_MAX_BYTES),
    .MAX_ITEM_BYTES  (MAX_ITEM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_cmd_i     (pop_cmd),
    .bstat_o     (bstat),
    .buf_raddr_o (buf_raddr),
    .buf_rdata_i (buf_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/bfm_checker.sv =====
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks of the bloom filter membership block.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_checker import bfm_pkg::*; (
  input wire      clk_i,
  input wire      rst_ni,
  input wire      in_ready_o,
  input wire      out_valid_o,
  input wire      out_ready_i,
  input bfm_out_t out_data_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a dropped element never reports membership
  a_long_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_too_long |-> !out_data_o.found)
    else $error("too long element reported as found");

  // the filter is swept right after reset, so no input is taken then
  a_clear_after_reset: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> !in_ready_o)
    else $error("input taken during reset clearing");

endmodule

bind bloom_filter_membership bfm_checker u_bfm_checker (.*);

`default_nettype wire
